/* hw/rtl/fbc_pkg.sv */
// Shared constants and types of the free block coalescer.
package fbc_pkg;

    localparam int ADDR_BITS  = 40;
    localparam int RATIO_BITS = 16;
    localparam int ALU_BITS   = ADDR_BITS + 1;
    localparam int CNT_BITS   = $clog2(RATIO_BITS);

    typedef struct packed {
        logic [ALU_BITS-1:0] op_a;
        logic [ALU_BITS-1:0] op_b;
        logic                sub;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_BITS-1:0] sum;
        logic                carry;
    } alu_rsp_t;

    typedef struct packed {
        logic                  valid;
        logic [ADDR_BITS-1:0]  addr;
        logic [ADDR_BITS-1:0]  size;
        logic                  free;
        logic                  last;
        logic [ADDR_BITS-1:0]  reclaimed;
        logic [RATIO_BITS-1:0] frag;
    } emit_t;

endpackage

/* hw/rtl/fbc_ifs.sv */
// Valid/ready channel interfaces for block descriptors and result words.
interface fbc_in_if
    import fbc_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [ADDR_BITS-1:0] block_addr;
    logic [ADDR_BITS-1:0] block_size;
    logic                 block_free;
    logic                 block_last;

    modport source (output valid, block_addr, block_size, block_free, block_last,
                    input ready);
    modport sink (input valid, block_addr, block_size, block_free, block_last,
                  output ready);
endinterface

interface fbc_out_if
    import fbc_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [ADDR_BITS-1:0]  out_addr;
    logic [ADDR_BITS-1:0]  out_size;
    logic                  out_free;
    logic                  out_last;
    logic [ADDR_BITS-1:0]  reclaimed_bytes;
    logic [RATIO_BITS-1:0] frag_ratio;

    modport source (output valid, out_addr, out_size, out_free, out_last,
                    reclaimed_bytes, frag_ratio, input ready);
    modport sink (input valid, out_addr, out_size, out_free, out_last,
                  reclaimed_bytes, frag_ratio, output ready);
endinterface

/* hw/rtl/fbc_alu.sv */
// Shared adder/subtractor used by the arithmetic steps of the sequencer.
module fbc_alu
    import fbc_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [ALU_BITS-1:0] op_b_eff;
    logic [ALU_BITS:0]   total;

    assign op_b_eff  = req.sub ? ~req.op_b : req.op_b;
    assign total     = {1'b0, req.op_a} + {1'b0, op_b_eff} + {{ALU_BITS{1'b0}}, req.sub};
    assign rsp.sum   = total[ALU_BITS-1:0];
    assign rsp.carry = total[ALU_BITS];

endmodule

/* hw/rtl/fbc_seq.sv */
// Sequencer holding the pending block and pass totals, driving the shared ALU.
module fbc_seq
    import fbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    fbc_in_if.sink      blk,
    input  logic        slot_free,
    output emit_t       emit,
    output alu_req_t    alu_req,
    input  alu_rsp_t    alu_rsp
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHK   = 4'd1;
    localparam logic [3:0] S_MSIZE = 4'd2;
    localparam logic [3:0] S_MRCL  = 4'd3;
    localparam logic [3:0] S_ACC   = 4'd4;
    localparam logic [3:0] S_MAX   = 4'd5;
    localparam logic [3:0] S_DSUB  = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;
    localparam logic [3:0] S_LOAD  = 4'd9;

    logic [3:0]            state_reg, state_next;
    logic [ADDR_BITS-1:0]  in_addr_reg, in_addr_next;
    logic [ADDR_BITS-1:0]  in_size_reg, in_size_next;
    logic                  in_free_reg, in_free_next;
    logic                  in_last_reg, in_last_next;
    logic                  pv_reg, pv_next;
    logic [ADDR_BITS-1:0]  pa_reg, pa_next;
    logic [ADDR_BITS-1:0]  ps_reg, ps_next;
    logic                  pf_reg, pf_next;
    logic [ADDR_BITS-1:0]  rcl_reg, rcl_next;
    logic [ADDR_BITS-1:0]  ft_reg, ft_next;
    logic [ADDR_BITS-1:0]  lg_reg, lg_next;
    logic                  fin_reg, fin_next;
    logic [ADDR_BITS-1:0]  rem_reg, rem_next;
    logic [RATIO_BITS-1:0] quo_reg, quo_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [ADDR_BITS-1:0]  sat_sum;
    logic                  adjacent;

    assign blk.ready = (state_reg == S_IDLE);
    assign sat_sum   = alu_rsp.sum[ADDR_BITS] ? {ADDR_BITS{1'b1}}
                                              : alu_rsp.sum[ADDR_BITS-1:0];
    assign adjacent  = !alu_rsp.sum[ADDR_BITS] && (alu_rsp.sum[ADDR_BITS-1:0] == in_addr_reg);

    always_comb
    begin
        alu_req = '0;
        unique case (state_reg)
            S_CHK:
            begin
                alu_req.op_a = {1'b0, pa_reg};
                alu_req.op_b = {1'b0, ps_reg};
            end
            S_MSIZE:
            begin
                alu_req.op_a = {1'b0, ps_reg};
                alu_req.op_b = {1'b0, in_size_reg};
            end
            S_MRCL:
            begin
                alu_req.op_a = {1'b0, rcl_reg};
                alu_req.op_b = {1'b0, in_size_reg};
            end
            S_ACC:
            begin
                alu_req.op_a = {1'b0, ft_reg};
                alu_req.op_b = {1'b0, ps_reg};
            end
            S_MAX:
            begin
                alu_req.op_a = {1'b0, lg_reg};
                alu_req.op_b = {1'b0, ps_reg};
                alu_req.sub  = 1'b1;
            end
            S_DSUB:
            begin
                alu_req.op_a = {1'b0, ft_reg};
                alu_req.op_b = {1'b0, lg_reg};
                alu_req.sub  = 1'b1;
            end
            S_DIV:
            begin
                alu_req.op_a = {rem_reg, 1'b0};
                alu_req.op_b = {1'b0, ft_reg};
                alu_req.sub  = 1'b1;
            end
            default:
            begin
                alu_req = '0;
            end
        endcase
    end

    always_comb
    begin
        emit.valid     = (state_reg == S_EMIT) && slot_free;
        emit.addr      = pa_reg;
        emit.size      = ps_reg;
        emit.free      = pf_reg;
        emit.last      = fin_reg;
        emit.reclaimed = fin_reg ? rcl_reg : '0;
        emit.frag      = fin_reg ? quo_reg : '0;
    end

    always_comb
    begin
        state_next   = state_reg;
        in_addr_next = in_addr_reg;
        in_size_next = in_size_reg;
        in_free_next = in_free_reg;
        in_last_next = in_last_reg;
        pv_next      = pv_reg;
        pa_next      = pa_reg;
        ps_next      = ps_reg;
        pf_next      = pf_reg;
        rcl_next     = rcl_reg;
        ft_next      = ft_reg;
        lg_next      = lg_reg;
        fin_next     = fin_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        cnt_next     = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (blk.valid)
                begin
                    in_addr_next = blk.block_addr;
                    in_size_next = blk.block_size;
                    in_free_next = blk.block_free;
                    in_last_next = blk.block_last;
                    state_next   = S_CHK;
                end
            end
            S_CHK:
            begin
                if (pv_reg && pf_reg && in_free_reg && adjacent)
                    state_next = S_MSIZE;
                else if (pv_reg)
                    state_next = S_ACC;
                else
                    state_next = S_LOAD;
            end
            S_MSIZE:
            begin
                ps_next    = sat_sum;
                state_next = S_MRCL;
            end
            S_MRCL:
            begin
                rcl_next = sat_sum;
                if (in_last_reg)
                begin
                    fin_next   = 1'b1;
                    state_next = S_ACC;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_ACC:
            begin
                if (pf_reg)
                    ft_next = sat_sum;
                state_next = S_MAX;
            end
            S_MAX:
            begin
                if (pf_reg && !alu_rsp.carry)
                    lg_next = ps_reg;
                state_next = fin_reg ? S_DSUB : S_EMIT;
            end
            S_DSUB:
            begin
                quo_next = '0;
                cnt_next = '0;
                rem_next = alu_rsp.sum[ADDR_BITS-1:0];
                state_next = (ft_reg == '0) ? S_EMIT : S_DIV;
            end
            S_DIV:
            begin
                if (alu_rsp.carry)
                begin
                    rem_next = alu_rsp.sum[ADDR_BITS-1:0];
                    quo_next = {quo_reg[RATIO_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[ADDR_BITS-2:0], 1'b0};
                    quo_next = {quo_reg[RATIO_BITS-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(RATIO_BITS - 1))
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    if (fin_reg)
                    begin
                        pv_next    = 1'b0;
                        pa_next    = '0;
                        ps_next    = '0;
                        pf_next    = 1'b0;
                        rcl_next   = '0;
                        ft_next    = '0;
                        lg_next    = '0;
                        fin_next   = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_LOAD;
                    end
                end
            end
            S_LOAD:
            begin
                pv_next = 1'b1;
                pa_next = in_addr_reg;
                ps_next = in_size_reg;
                pf_next = in_free_reg;
                if (in_last_reg)
                begin
                    fin_next   = 1'b1;
                    state_next = S_ACC;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pv_reg    <= 1'b0;
            pa_reg    <= '0;
            ps_reg    <= '0;
            pf_reg    <= 1'b0;
            rcl_reg   <= '0;
            ft_reg    <= '0;
            lg_reg    <= '0;
            fin_reg   <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pv_reg    <= pv_next;
            pa_reg    <= pa_next;
            ps_reg    <= ps_next;
            pf_reg    <= pf_next;
            rcl_reg   <= rcl_next;
            ft_reg    <= ft_next;
            lg_reg    <= lg_next;
            fin_reg   <= fin_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_addr_reg <= in_addr_next;
        in_size_reg <= in_size_next;
        in_free_reg <= in_free_next;
        in_last_reg <= in_last_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
    end

endmodule

/* hw/rtl/free_block_coalescer_top.sv */
// Top level of the free block coalescer: sequencer, shared ALU and output register.
//
//  channel | dir | payload
//  blk     | in  | block_addr, block_size, block_free, block_last
//  res     | out | out_addr, out_size, out_free, out_last, reclaimed_bytes, frag_ratio
//
// A descriptor that merges runs the check, size and reclaim steps, the first one of a pass
// runs the check and load steps, and one that emits the pending block runs the check,
// accumulate, max, emit and load steps. The final descriptor adds the accumulate, max,
// subtract and emit steps, plus a restoring division when free space was emitted, one
// quotient bit per cycle through the shared ALU. A full output register stalls the
// sequencer at the emit step; reset is asynchronous and needs no clearing pass.
module free_block_coalescer_top
    import fbc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    fbc_in_if.sink  blk,
    fbc_out_if.source res
);

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;
    emit_t    emit;
    logic     slot_free;
    logic     out_valid_reg, out_valid_next;
    emit_t    out_word_reg;

    fbc_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    fbc_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .blk       (blk),
        .slot_free (slot_free),
        .emit      (emit),
        .alu_req   (alu_req),
        .alu_rsp   (alu_rsp)
    );

    assign slot_free = !out_valid_reg || res.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit.valid)
            out_valid_next = 1'b1;
        else if (res.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
            out_word_reg <= emit;
    end

    assign res.valid           = out_valid_reg;
    assign res.out_addr        = out_word_reg.addr;
    assign res.out_size        = out_word_reg.size;
    assign res.out_free        = out_word_reg.free;
    assign res.out_last        = out_word_reg.last;
    assign res.reclaimed_bytes = out_word_reg.reclaimed;
    assign res.frag_ratio      = out_word_reg.frag;

endmodule

/* hw/rtl/fbc_checker.sv */
// Port-level assertions for the free block coalescer and their bind.
module fbc_checker
    import fbc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [ADDR_BITS-1:0]  out_addr,
    input logic                  out_last,
    input logic [ADDR_BITS-1:0]  reclaimed_bytes,
    input logic [RATIO_BITS-1:0] frag_ratio
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("Result word dropped while stalled.");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_addr) && $stable(out_last))
        else $error("Stalled result word changed.");

    a_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |-> reclaimed_bytes == '0 && frag_ratio == '0)
        else $error("Summary fields set on a word that is not last.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("Descriptor accepted while the previous one is at work.");

endmodule

bind free_block_coalescer_top fbc_checker u_fbc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (blk.valid),
    .in_ready        (blk.ready),
    .out_valid       (res.valid),
    .out_ready       (res.ready),
    .out_addr        (res.out_addr),
    .out_last        (res.out_last),
    .reclaimed_bytes (res.reclaimed_bytes),
    .frag_ratio      (res.frag_ratio)
);

/* sim/tb.sv */
// Self-checking testbench of the free block coalescer with a queue-fed driver and a monitor.
module tb;
    import fbc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [ADDR_BITS-1:0] addr;
        logic [ADDR_BITS-1:0] size;
        logic                 free;
        logic                 last;
    } desc_t;

    typedef struct {
        logic [ADDR_BITS-1:0]  addr;
        logic [ADDR_BITS-1:0]  size;
        logic                  free;
        logic                  last;
        logic [ADDR_BITS-1:0]  reclaimed;
        logic [RATIO_BITS-1:0] frag;
    } coal_word_t;

    localparam logic [ADDR_BITS-1:0] ADDR_MAX = '1;

    logic clk;
    logic rst_n;

    fbc_in_if  blk_if ();
    fbc_out_if res_if ();

    free_block_coalescer_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .blk   (blk_if),
        .res   (res_if)
    );

    desc_t      desc_queue[$];
    coal_word_t coalesced_queue[$];
    desc_t      desc_on_bus;
    int         errors;
    int         cycle;

    logic                 hold_valid;
    logic [ADDR_BITS-1:0] hold_addr;
    logic [ADDR_BITS-1:0] hold_size;
    logic                 hold_free;
    logic [ADDR_BITS-1:0] reclaimed_sum;
    logic [ADDR_BITS-1:0] free_sum;
    logic [ADDR_BITS-1:0] largest_size;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
    end

    function automatic bit idle_now();
        if (cycle >= 1500 && cycle < 2500)
            return 1'b0;
        return $urandom_range(0, 99) < 17;
    endfunction

    function automatic logic [ADDR_BITS-1:0] rand40();
        logic [31:0] lo;
        logic [31:0] hi;
        lo = $urandom;
        hi = $urandom;
        return {hi[ADDR_BITS-33:0], lo};
    endfunction

    function automatic logic [ADDR_BITS-1:0] sat_sum(logic [ADDR_BITS-1:0] a,
                                                     logic [ADDR_BITS-1:0] b);
        logic [ADDR_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[ADDR_BITS] ? ADDR_MAX : s[ADDR_BITS-1:0];
    endfunction

    task automatic emit_pending(bit last_flag);
        coal_word_t w;
        logic [63:0] num;
        logic [63:0] quo;
        if (hold_free)
        begin
            free_sum = sat_sum(free_sum, hold_size);
            if (hold_size > largest_size)
                largest_size = hold_size;
        end
        w.addr = hold_addr;
        w.size = hold_size;
        w.free = hold_free;
        w.last = last_flag;
        w.reclaimed = last_flag ? reclaimed_sum : '0;
        w.frag = '0;
        if (last_flag && free_sum != 0)
        begin
            num = 64'(free_sum - largest_size) << RATIO_BITS;
            quo = num / 64'(free_sum);
            w.frag = quo[RATIO_BITS-1:0];
        end
        coalesced_queue.push_back(w);
    endtask

    task automatic predict_coalesce(desc_t d);
        logic [ADDR_BITS:0] end_addr;
        bit merged;
        merged = 1'b0;
        end_addr = {1'b0, hold_addr} + {1'b0, hold_size};
        if (hold_valid && hold_free && d.free && !end_addr[ADDR_BITS]
            && end_addr[ADDR_BITS-1:0] == d.addr)
        begin
            hold_size = sat_sum(hold_size, d.size);
            reclaimed_sum = sat_sum(reclaimed_sum, d.size);
            merged = 1'b1;
        end
        if (!merged)
        begin
            if (hold_valid)
                emit_pending(1'b0);
            hold_valid = 1'b1;
            hold_addr = d.addr;
            hold_size = d.size;
            hold_free = d.free;
        end
        if (d.last)
        begin
            emit_pending(1'b1);
            hold_valid = 1'b0;
            hold_addr = '0;
            hold_size = '0;
            hold_free = 1'b0;
            reclaimed_sum = '0;
            free_sum = '0;
            largest_size = '0;
        end
    endtask

    task automatic add_desc(logic [ADDR_BITS-1:0] a, logic [ADDR_BITS-1:0] s,
                            logic f, logic l);
        desc_t d;
        d.addr = a;
        d.size = s;
        d.free = f;
        d.last = l;
        desc_queue.push_back(d);
    endtask

    function automatic logic [ADDR_BITS-1:0] rand_size();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            return ADDR_BITS'($urandom_range(0, 4096));
        if (pick < 90)
            return rand40();
        return ADDR_MAX - ADDR_BITS'($urandom_range(0, 15));
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            blk_if.valid <= 1'b0;
        end
        else
        begin
            if (blk_if.valid && blk_if.ready)
                predict_coalesce(desc_on_bus);
            if (!blk_if.valid || blk_if.ready)
            begin
                if (desc_queue.size() > 0 && !idle_now())
                begin
                    desc_on_bus = desc_queue.pop_front();
                    blk_if.valid      <= 1'b1;
                    blk_if.block_addr <= desc_on_bus.addr;
                    blk_if.block_size <= desc_on_bus.size;
                    blk_if.block_free <= desc_on_bus.free;
                    blk_if.block_last <= desc_on_bus.last;
                end
                else
                begin
                    blk_if.valid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        coal_word_t w;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (coalesced_queue.size() == 0)
            begin
                $display("%0t: unexpected word: expected none, actual addr %h size %h last %b",
                         $time, res_if.out_addr, res_if.out_size, res_if.out_last);
                errors++;
            end
            else
            begin
                w = coalesced_queue.pop_front();
                check_field("out_addr", 64'(w.addr), 64'(res_if.out_addr));
                check_field("out_size", 64'(w.size), 64'(res_if.out_size));
                check_field("out_free", 64'(w.free), 64'(res_if.out_free));
                check_field("out_last", 64'(w.last), 64'(res_if.out_last));
                check_field("reclaimed_bytes", 64'(w.reclaimed), 64'(res_if.reclaimed_bytes));
                check_field("frag_ratio", 64'(w.frag), 64'(res_if.frag_ratio));
            end
        end
        res_if.ready <= rst_n && !idle_now();
    end

    initial
    begin
        #2000000;
        $display("FAIL free_block_coalescer_top");
        $finish;
    end

    initial
    begin
        int total;
        int len;
        logic [ADDR_BITS-1:0] a;
        logic [ADDR_BITS-1:0] s;
        logic f;

        clk = 1'b0;
        rst_n = 1'b0;
        errors = 0;
        cycle = 0;
        blk_if.valid = 1'b0;
        blk_if.block_addr = '0;
        blk_if.block_size = '0;
        blk_if.block_free = 1'b0;
        blk_if.block_last = 1'b0;
        res_if.ready = 1'b0;
        hold_valid = 1'b0;
        hold_addr = '0;
        hold_size = '0;
        hold_free = 1'b0;
        reclaimed_sum = '0;
        free_sum = '0;
        largest_size = '0;

        // Single-descriptor lists, free and allocated.
        add_desc(40'h10, 40'h20, 1'b1, 1'b1);
        add_desc(ADDR_MAX, ADDR_MAX, 1'b0, 1'b1);
        // Merge of two free blocks, then an allocated one and a free tail.
        add_desc(40'h0, 40'h100, 1'b1, 1'b0);
        add_desc(40'h100, 40'h80, 1'b1, 1'b0);
        add_desc(40'h180, 40'h40, 1'b0, 1'b0);
        add_desc(40'h1C0, 40'h40, 1'b1, 1'b1);
        // End address wraps past the top, so no merge.
        add_desc(ADDR_MAX - 40'hF, 40'h20, 1'b1, 1'b0);
        add_desc(40'h10, 40'h30, 1'b1, 1'b1);
        // Saturating merged size and free total.
        add_desc(40'h0, ADDR_MAX, 1'b1, 1'b0);
        add_desc(ADDR_MAX, ADDR_MAX, 1'b1, 1'b0);
        add_desc(40'h5, ADDR_MAX, 1'b1, 1'b1);
        // Zero sizes merge at the same address.
        add_desc(40'h1000, 40'h0, 1'b1, 1'b0);
        add_desc(40'h1000, 40'h0, 1'b1, 1'b0);
        add_desc(40'h1000, 40'h5, 1'b1, 1'b1);
        // Allocated block followed by an adjacent free block does not merge.
        add_desc(40'h2000, 40'h100, 1'b0, 1'b0);
        add_desc(40'h2100, 40'h100, 1'b1, 1'b0);
        add_desc(40'h2200, 40'h100, 1'b0, 1'b0);
        add_desc(40'h0, 40'h0, 1'b0, 1'b1);

        total = 0;
        while (total < 400)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 10);
                a = ($urandom_range(0, 9) == 0) ? ADDR_MAX - ADDR_BITS'($urandom_range(0, 8192))
                                               : rand40();
                for (int i = 0; i < len; i++)
                begin
                    s = rand_size();
                    f = $urandom_range(0, 99) < 60;
                    add_desc(a, s, f, i == len - 1);
                    if ($urandom_range(0, 99) < 85)
                        a = a + s;
                    else
                        a = rand40();
                end
                total += len;
            end
            else
            begin
                add_desc(rand40(), rand40(), 1'($urandom_range(0, 1)),
                         $urandom_range(0, 99) < 30);
                total++;
            end
        end
        add_desc(rand40(), rand40(), 1'($urandom_range(0, 1)), 1'b1);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (desc_queue.size() > 0 || blk_if.valid)
            @(posedge clk);
        while (coalesced_queue.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (errors == 0)
            $display("PASS free_block_coalescer_top");
        else
            $display("FAIL free_block_coalescer_top");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/fbc_pkg.sv
hw/rtl/fbc_ifs.sv
hw/rtl/fbc_alu.sv
hw/rtl/fbc_seq.sv
hw/rtl/free_block_coalescer_top.sv
hw/rtl/fbc_checker.sv
sim/tb.sv
